// File: hdl/box_count_occupancy_core_defines.svh
// Assertion macros used by the box counting core.
`ifndef BOX_COUNT_OCCUPANCY_CORE_DEFINES_SVH
`define BOX_COUNT_OCCUPANCY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCO_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCO_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bco_pkg.sv
package bco_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int NUM_SIZES  = 3;
    localparam int OUT_SIZES  = 3;

    localparam int CFG_W = 11;
    localparam int CNT_W = 21;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;

    localparam int PIX_W   = 8;
    localparam int IN_W    = 2 * PIX_W;
    localparam int OUT_W   = 2 * OUT_SIZES * CNT_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_BOX_FIRST    = 3'd2,
        REG_BOX_SECOND   = 3'd3,
        REG_BOX_THIRD    = 3'd4
    } reg_idx_t;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd720;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd400;
    localparam logic [CFG_W-1:0] RST_BOX_FIRST    = 11'd3;
    localparam logic [CFG_W-1:0] RST_BOX_SECOND   = 11'd5;
    localparam logic [CFG_W-1:0] RST_BOX_THIRD    = 11'd51;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [OUT_SIZES-1:0][CFG_W-1:0] box_size;
    } cfg_t;

    // Per-pixel control handed to every box grid.
    typedef struct packed {
        logic fire;
        logic restart;
        logic mark;
        logic last_col;
        logic last_row;
    } step_t;

    // Zero reads as one; anything above the limit saturates.
    function automatic logic [COL_W:0] clamp_width(logic [CFG_W-1:0] v);
        logic [COL_W:0] r;
        if (v == '0) begin
            r = (COL_W+1)'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            r = (COL_W+1)'(MAX_WIDTH);
        end else begin
            r = (COL_W+1)'(v);
        end
        return r;
    endfunction

    function automatic logic [ROW_W:0] clamp_height(logic [CFG_W-1:0] v);
        logic [ROW_W:0] r;
        if (v == '0) begin
            r = (ROW_W+1)'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            r = (ROW_W+1)'(v);
        end
        return r;
    endfunction

endpackage

// File: hdl/bco_ram.sv
module bco_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/bco_regs.sv
module bco_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bco_pkg::APB_AW-1:0]   paddr,
    input  logic [bco_pkg::APB_DW-1:0]   pwdata,
    output logic [bco_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output bco_pkg::cfg_t                cfg,
    output logic                         cfg_wr
);

    bco_pkg::cfg_t     cfg_reg;
    bco_pkg::cfg_t     cfg_next;
    bco_pkg::reg_idx_t idx;
    logic              wr_en;
    logic [bco_pkg::CFG_W-1:0] wval;
    logic [bco_pkg::CFG_W-1:0] rval;

    assign pready = 1'b1;
    assign idx    = bco_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wval   = pwdata[bco_pkg::CFG_W-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        cfg_wr   = 1'b0;
        if (wr_en) begin
            cfg_wr = 1'b1;
            case (idx)
                bco_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = wval;
                bco_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = wval;
                bco_pkg::REG_BOX_FIRST:    cfg_next.box_size[0]  = wval;
                bco_pkg::REG_BOX_SECOND:   cfg_next.box_size[1]  = wval;
                bco_pkg::REG_BOX_THIRD:    cfg_next.box_size[2]  = wval;
                default:                   cfg_wr = 1'b0;
            endcase
        end
    end

    always_comb begin
        case (idx)
            bco_pkg::REG_IMAGE_WIDTH:  rval = cfg_reg.image_width;
            bco_pkg::REG_IMAGE_HEIGHT: rval = cfg_reg.image_height;
            bco_pkg::REG_BOX_FIRST:    rval = cfg_reg.box_size[0];
            bco_pkg::REG_BOX_SECOND:   rval = cfg_reg.box_size[1];
            bco_pkg::REG_BOX_THIRD:    rval = cfg_reg.box_size[2];
            default:                   rval = '0;
        endcase
    end

    assign prdata = bco_pkg::APB_DW'(rval);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= bco_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= bco_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.box_size[0]  <= bco_pkg::RST_BOX_FIRST;
            cfg_reg.box_size[1]  <= bco_pkg::RST_BOX_SECOND;
            cfg_reg.box_size[2]  <= bco_pkg::RST_BOX_THIRD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/bco_grid.sv
module bco_grid (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bco_pkg::step_t              step,
    input  logic [bco_pkg::CFG_W-1:0]   box_size,
    output logic [bco_pkg::CNT_W-1:0]   occupied_upd,
    output logic [bco_pkg::CNT_W-1:0]   total_upd
);

    localparam int COL_W = bco_pkg::COL_W;
    localparam int ROW_W = bco_pkg::ROW_W;
    localparam int CMP_W = bco_pkg::CMP_W;
    localparam int CNT_W = bco_pkg::CNT_W;

    logic [COL_W-1:0] col_off_reg, col_off_next;
    logic [ROW_W-1:0] row_off_reg, row_off_next;
    logic [COL_W-1:0] bcol_reg, bcol_next;
    logic             acc_reg, acc_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] tot_reg, tot_next;
    logic             hit_reg, hit_next;
    logic             hit_data_reg;

    logic [CMP_W-1:0] size_eff;
    logic             end_c;
    logic             end_r;
    logic             box_done;
    logic             ram_rdata;
    logic             band_flag;
    logic             flag;
    logic             we;

    assign size_eff = (box_size == '0) ? CMP_W'(1) : CMP_W'(box_size);
    assign end_c    = (CMP_W'(col_off_reg) + CMP_W'(1) >= size_eff) || step.last_col;
    assign end_r    = (CMP_W'(row_off_reg) + CMP_W'(1) >= size_eff) || step.last_row;
    assign box_done = end_c && end_r;

    // The band flag of the current box column; a write in the previous cycle
    // to the address now being read is forwarded around the memory.
    assign band_flag = hit_reg ? hit_data_reg : ram_rdata;

    always_comb begin
        if (col_off_reg != '0) begin
            flag = acc_reg | step.mark;
        end else if (row_off_reg != '0) begin
            flag = band_flag | step.mark;
        end else begin
            flag = step.mark;
        end
    end

    assign occupied_upd = occ_reg + CNT_W'(box_done && flag);
    assign total_upd    = tot_reg + CNT_W'(box_done);

    always_comb begin
        col_off_next = col_off_reg;
        row_off_next = row_off_reg;
        bcol_next    = bcol_reg;
        acc_next     = acc_reg;
        occ_next     = occ_reg;
        tot_next     = tot_reg;
        if (step.fire) begin
            acc_next = flag;
            occ_next = occupied_upd;
            tot_next = total_upd;
            if (end_c) begin
                col_off_next = '0;
                bcol_next    = step.last_col ? '0 : bcol_reg + COL_W'(1);
            end else begin
                col_off_next = col_off_reg + COL_W'(1);
            end
            if (step.last_col) begin
                row_off_next = end_r ? '0 : row_off_reg + ROW_W'(1);
            end
        end
        if (step.restart) begin
            col_off_next = '0;
            row_off_next = '0;
            bcol_next    = '0;
            occ_next     = '0;
            tot_next     = '0;
        end
    end

    assign we       = step.fire && end_c;
    assign hit_next = we && (bcol_reg == bcol_next);

    bco_ram #(
        .WIDTH (1),
        .DEPTH (bco_pkg::MAX_WIDTH)
    ) u_band (
        .aclk  (aclk),
        .we    (we),
        .waddr (bcol_reg),
        .wdata (flag),
        .raddr (bcol_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_off_reg <= '0;
            row_off_reg <= '0;
            bcol_reg    <= '0;
            acc_reg     <= 1'b0;
            occ_reg     <= '0;
            tot_reg     <= '0;
            hit_reg     <= 1'b0;
        end else begin
            col_off_reg <= col_off_next;
            row_off_reg <= row_off_next;
            bcol_reg    <= bcol_next;
            acc_reg     <= acc_next;
            occ_reg     <= occ_next;
            tot_reg     <= tot_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_data_reg <= flag;
    end

endmodule

// File: hdl/box_count_occupancy_core.sv
// Box counting occupancy core.
// Pixels enter in raster order on the s_ stream, one transfer per pixel:
// s_tdata carries black_level in bits 7:0 and alpha_level in bits 15:8. A
// pixel is marked when its blackness is above one and its alpha is nonzero.
// For each of three box sizes the image is tiled from the top-left corner,
// partial boxes at the right and bottom edges included, and both the number
// of boxes and the number of boxes holding a marked pixel are counted.
// The last pixel of an image produces one transfer on the m_ stream with all
// six 21-bit counts; the scan then starts over with the next image.
// Image size and box sizes sit behind the APB port; a write restarts the scan.
// The user writes only while the core is idle; the core does not enforce this.
// Throughput is one pixel per cycle, except that an image's last pixel waits
// while a result is pending. A pixel transfer loads the input register; when
// that pixel retires, the counts update and, for the last pixel, the output
// register loads, from which the count transfer follows. The band flag RAM
// is read at the next column's address, so its data is ready for that column.
// When the receiver stalls with a result pending, pixels keep flowing until
// the next image's last pixel, which waits in the input register.
// Reset restores the default registers and clears the scan position.
module box_count_occupancy_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bco_pkg::APB_AW-1:0]     paddr,
    input  logic [bco_pkg::APB_DW-1:0]     pwdata,
    output logic [bco_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    // pixel stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bco_pkg::IN_W-1:0]       s_tdata,   // black_level, alpha_level
    // count stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // occupied_first, total_first, occupied_second, total_second,
    // occupied_third, total_third, zero padding
    output logic [bco_pkg::TDATA_W-1:0]    m_tdata
);

    `include "box_count_occupancy_core_defines.svh"

    localparam int COL_W = bco_pkg::COL_W;
    localparam int ROW_W = bco_pkg::ROW_W;
    localparam int CNT_W = bco_pkg::CNT_W;
    localparam int PIX_W = bco_pkg::PIX_W;
    localparam int NSZ   = bco_pkg::OUT_SIZES;

    bco_pkg::cfg_t  cfg;
    logic           cfg_wr;
    bco_pkg::step_t step;

    logic             in_valid_reg, in_valid_next;
    logic [PIX_W-1:0] black_reg;
    logic [PIX_W-1:0] alpha_reg;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] res_occ_reg [NSZ];
    logic [CNT_W-1:0] res_tot_reg [NSZ];

    logic [COL_W:0]   img_w;
    logic [ROW_W:0]   img_h;
    logic             last_col;
    logic             last_row;
    logic             pix_last;
    logic             out_free;
    logic             fire;
    logic             in_take;
    logic             mark;
    logic [CNT_W-1:0] grid_occ [NSZ];
    logic [CNT_W-1:0] grid_tot [NSZ];
    logic             img_done;
    logic             pos_ok;
    logic             at_origin;

    bco_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    assign img_w    = bco_pkg::clamp_width(cfg.image_width);
    assign img_h    = bco_pkg::clamp_height(cfg.image_height);
    assign last_col = ((COL_W+1)'(col_pos_reg) + (COL_W+1)'(1)) >= img_w;
    assign last_row = ((ROW_W+1)'(row_pos_reg) + (ROW_W+1)'(1)) >= img_h;
    assign pix_last = last_col && last_row;
    assign mark     = (black_reg > PIX_W'(1)) && (alpha_reg != '0);

    // The last pixel of an image may only retire when the result register
    // can take its counts; every other pixel retires unconditionally.
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = in_valid_reg && (!pix_last || out_free);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    assign step.fire     = fire;
    assign step.restart  = cfg_wr || (fire && pix_last);
    assign step.mark     = mark;
    assign step.last_col = last_col;
    assign step.last_row = last_row;

    // One grid per configured box size; absent sizes report zero counts.
    for (genvar s = 0; s < NSZ; s++) begin : g_size
        if (s < bco_pkg::NUM_SIZES) begin : g_on
            bco_grid u_grid (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .step         (step),
                .box_size     (cfg.box_size[s]),
                .occupied_upd (grid_occ[s]),
                .total_upd    (grid_tot[s])
            );
        end else begin : g_off
            assign grid_occ[s] = '0;
            assign grid_tot[s] = '0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (cfg_wr || (fire && pix_last)) begin
            col_pos_next = '0;
            row_pos_next = '0;
        end else if (fire) begin
            if (last_col) begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + ROW_W'(1);
            end else begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (fire && pix_last) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            black_reg <= s_tdata[PIX_W-1:0];
            alpha_reg <= s_tdata[2*PIX_W-1:PIX_W];
        end
        if (fire && pix_last) begin
            for (int s = 0; s < NSZ; s++) begin
                res_occ_reg[s] <= grid_occ[s];
                res_tot_reg[s] <= grid_tot[s];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(bco_pkg::TDATA_W - bco_pkg::OUT_W){1'b0}},
                       res_tot_reg[2], res_occ_reg[2],
                       res_tot_reg[1], res_occ_reg[1],
                       res_tot_reg[0], res_occ_reg[0]};

    assign img_done  = fire && pix_last;
    assign pos_ok    = ((COL_W+1)'(col_pos_reg) < img_w) && ((ROW_W+1)'(row_pos_reg) < img_h);
    assign at_origin = (col_pos_reg == '0) && (row_pos_reg == '0);

    // A count transfer is only raised by the last pixel of an image.
    `BCO_ASSERT_IMP(a_result_source, aclk, aresetn, $rose(m_tvalid), $past(img_done), "stray result")

    // The scan position always stays inside the configured image.
    `BCO_ASSERT_IMP(a_pos_in_image, aclk, aresetn, 1'b1, pos_ok, "scan position outside the image")

    // After the final pixel the next image starts at the origin.
    `BCO_ASSERT_NXT(a_scan_restart, aclk, aresetn, img_done, at_origin, "scan did not restart")

endmodule
